### design/adc_avg_pkg.sv
// shared types and constants for the adc average / delta report block
// used by adc_avg_front, adc_avg_fifo, adc_avg_back and the top level
package adc_avg_pkg;

  localparam int SAMPLE_W   = 12;
  localparam int CHAN_W     = 2;
  localparam int NUM_DELTAS = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_ENABLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DELTA_CH0      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DELTA_CH3      = 3'd4;

  // request queue between front and back
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = 2;

  // quotient bits resolved per divider cycle
  localparam int DIV_STEP = 4;

  typedef logic [SAMPLE_W-1:0] level_t;

  typedef struct packed {
    logic [CHAN_W-1:0] chan;
    level_t            sample;
  } item_t;

  typedef struct packed {
    level_t [NUM_DELTAS-1:0] delta;
    logic [NUM_DELTAS-1:0]   clr;
  } cfg_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_READ,
    B_UPDATE,
    B_DIV,
    B_CMP
  } back_state_t;

endpackage

### design/adc_avg_front.sv
// front end: configuration registers, input accept and channel filtering
// depends on adc_avg_pkg
module adc_avg_front #(
  parameter int CHANNELS = 4
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  adc_avg_pkg::item_t                   in_item,
  input  logic                                 wr_en,
  input  logic [adc_avg_pkg::CFG_IDX_W-1:0]    wr_index,
  input  logic [adc_avg_pkg::CFG_DATA_W-1:0]   wr_data,
  input  logic                                 fifo_full,
  output logic                                 push,
  output adc_avg_pkg::item_t                   push_item,
  output adc_avg_pkg::cfg_t                    cfg
);
  import adc_avg_pkg::*;

  logic [NUM_DELTAS-1:0] channel_enable;
  level_t [NUM_DELTAS-1:0] delta;
  logic [CHAN_W-1:0] delta_sel;
  logic chan_ok;

  assign delta_sel = CHAN_W'(wr_index - REG_DELTA_CH0);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      channel_enable <= '0;
      delta          <= '0;
    end else if (wr_en) begin
      if (wr_index == REG_CHANNEL_ENABLE) begin
        channel_enable <= wr_data[NUM_DELTAS-1:0];
      end else if (wr_index inside {[REG_DELTA_CH0:REG_DELTA_CH3]}) begin
        delta[delta_sel] <= wr_data;
      end
    end
  end

  // channels turning on get their last level cleared in the back end
  always_comb begin
    cfg.delta = delta;
    cfg.clr   = '0;
    if (wr_en && wr_index == REG_CHANNEL_ENABLE) begin
      cfg.clr = wr_data[NUM_DELTAS-1:0] & ~channel_enable;
    end
  end

  // accept while the queue has room, keep only enabled channels
  assign chan_ok       = (32'(in_item.chan) < CHANNELS) && channel_enable[in_item.chan];
  assign s_axis_tready = !fifo_full;
  assign push          = s_axis_tvalid && !fifo_full && chan_ok;
  assign push_item     = in_item;

endmodule

### design/adc_avg_fifo.sv
// short request queue between front and back end
// depends on adc_avg_pkg
module adc_avg_fifo (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  adc_avg_pkg::item_t push_item,
  output logic               full,
  input  logic               pop,
  output adc_avg_pkg::item_t pop_item,
  output logic               empty
);
  import adc_avg_pkg::*;

  item_t                 slots [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;
  logic [FIFO_PTR_W:0]   count;
  logic                  do_push;
  logic                  do_pop;

  assign full     = (count == (FIFO_PTR_W + 1)'(FIFO_DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_item = slots[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (!do_push && do_pop) count <= count - 1'b1;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_item;
  end

endmodule

### design/adc_avg_back.sv
// back end: sample rings, running sums, divider, deadband compare, output register
// depends on adc_avg_pkg
module adc_avg_back #(
  parameter int CHANNELS    = 4,
  parameter int AVG_SAMPLES = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  adc_avg_pkg::cfg_t                 cfg,
  input  logic                              fifo_empty,
  input  adc_avg_pkg::item_t                pop_item,
  output logic                              pop,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [adc_avg_pkg::CHAN_W-1:0]    report_chan,
  output adc_avg_pkg::level_t               report_level
);
  import adc_avg_pkg::*;

  localparam int CH_IW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int HEAD_W  = (AVG_SAMPLES > 1) ? $clog2(AVG_SAMPLES) : 1;
  localparam int CNT_W   = $clog2(AVG_SAMPLES + 1);
  localparam int SUM_W   = SAMPLE_W + ((AVG_SAMPLES > 1) ? $clog2(AVG_SAMPLES) : 0);
  localparam int DIV_CYC = (SUM_W + DIV_STEP - 1) / DIV_STEP;
  localparam int DIV_W   = DIV_CYC * DIV_STEP;
  localparam int DC_W    = (DIV_CYC > 1) ? $clog2(DIV_CYC) : 1;
  localparam int DEPTH   = CHANNELS * AVG_SAMPLES;
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  back_state_t state;
  back_state_t state_next;

  // per channel state
  logic [HEAD_W-1:0] head       [CHANNELS];
  logic [CNT_W-1:0]  fill       [CHANNELS];
  logic [SUM_W-1:0]  sum        [CHANNELS];
  level_t            last_level [CHANNELS];

  // sample rings
  level_t ring [DEPTH];
  level_t old_sample;

  logic [CHAN_W-1:0] cur_chan;
  level_t            cur_sample;
  logic [CH_IW-1:0]  ch_idx;
  logic [ADDR_W-1:0] addr;

  // divider
  logic [DIV_W-1:0] div_q;
  logic [CNT_W-1:0] div_rem;
  logic [CNT_W-1:0] div_d;
  logic [DC_W-1:0]  div_cnt;
  logic [DIV_W-1:0] div_q_next;
  logic [CNT_W-1:0] div_rem_next;

  logic             ring_full;
  logic [SUM_W-1:0] sum_next;
  logic [CNT_W-1:0] fill_next;
  level_t           level;
  level_t           last;
  level_t           delta;
  logic             fire;
  logic             out_load;
  logic [CHANNELS-1:0] clr_ext;

  assign ch_idx  = CH_IW'(cur_chan);
  assign addr    = ADDR_W'(32'(ch_idx) * AVG_SAMPLES + 32'(head[ch_idx]));
  assign clr_ext = CHANNELS'(cfg.clr);

  // running sum update
  assign ring_full = (fill[ch_idx] == CNT_W'(AVG_SAMPLES));
  assign sum_next  = ring_full ? sum[ch_idx] - SUM_W'(old_sample) + SUM_W'(cur_sample)
                               : sum[ch_idx] + SUM_W'(cur_sample);
  assign fill_next = ring_full ? fill[ch_idx] : fill[ch_idx] + 1'b1;

  // restoring division, several quotient bits per cycle
  always_comb begin
    logic [CNT_W:0] sh;
    div_q_next   = div_q;
    div_rem_next = div_rem;
    for (int k = 0; k < DIV_STEP; k++) begin
      sh         = {div_rem_next, div_q_next[DIV_W-1]};
      div_q_next = {div_q_next[DIV_W-2:0], 1'b0};
      if (sh >= {1'b0, div_d}) begin
        sh            = sh - {1'b0, div_d};
        div_q_next[0] = 1'b1;
      end
      div_rem_next = sh[CNT_W-1:0];
    end
  end

  // deadband compare against the last reported level
  assign level = div_q[SAMPLE_W-1:0];
  assign last  = last_level[ch_idx];
  assign delta = cfg.delta[cur_chan];
  always_comb begin
    fire = 1'b0;
    if (level > last) begin
      fire = ({1'b0, last} + {1'b0, delta}) < {1'b0, level};
    end else if (level < last) begin
      fire = (last >= delta) && ((last - delta) > level);
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      B_IDLE:   if (!fifo_empty) state_next = B_READ;
      B_READ:   state_next = B_UPDATE;
      B_UPDATE: state_next = B_DIV;
      B_DIV:    if (div_cnt == DC_W'(DIV_CYC - 1)) state_next = B_CMP;
      B_CMP:    if (!fire || !m_axis_tvalid || m_axis_tready) state_next = B_IDLE;
      default:  state_next = B_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    pop      = 1'b0;
    out_load = 1'b0;
    case (state)
      B_IDLE:  pop = !fifo_empty;
      B_CMP:   out_load = fire && (!m_axis_tvalid || m_axis_tready);
      default: begin
        pop      = 1'b0;
        out_load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= B_IDLE;
    else     state <= state_next;
  end

  // ring memory: read old entry, then overwrite it
  always_ff @(posedge clk) begin
    if (state == B_READ)   old_sample <= ring[addr];
    if (state == B_UPDATE) ring[addr] <= cur_sample;
  end

  // request latch and divider registers
  always_ff @(posedge clk) begin
    if (pop) begin
      cur_chan   <= pop_item.chan;
      cur_sample <= pop_item.sample;
    end
    if (state == B_UPDATE) begin
      div_q   <= DIV_W'(sum_next);
      div_rem <= '0;
      div_d   <= fill_next;
    end else if (state == B_DIV) begin
      div_q   <= div_q_next;
      div_rem <= div_rem_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (state == B_DIV) begin
      div_cnt <= (div_cnt == DC_W'(DIV_CYC - 1)) ? '0 : div_cnt + 1'b1;
    end
  end

  // per channel head, fill count, sum and last level
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < CHANNELS; c++) begin
        head[c]       <= '0;
        fill[c]       <= '0;
        sum[c]        <= '0;
        last_level[c] <= '0;
      end
    end else begin
      for (int c = 0; c < CHANNELS; c++) begin
        if (clr_ext[c]) last_level[c] <= '0;
      end
      if (state == B_UPDATE) begin
        head[ch_idx] <= (head[ch_idx] == HEAD_W'(AVG_SAMPLES - 1)) ? '0
                                                                   : head[ch_idx] + 1'b1;
        fill[ch_idx] <= fill_next;
        sum[ch_idx]  <= sum_next;
      end
      if (out_load) last_level[ch_idx] <= level;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      report_chan  <= cur_chan;
      report_level <= level;
    end
  end

endmodule

### design/adc_average_delta_report.sv
// Per-channel moving average of converter samples with a deadband change report.
// Each accepted sample for an enabled channel goes into that channel's ring of the
// last AVG_SAMPLES samples; the average of the filled entries is compared with the
// last reported level and a request {channel, level} is sent when it moved by more
// than the channel's delta. The front end takes one sample per cycle while its
// four-entry queue has room; samples for disabled channels are dropped at once.
// The back end handles one kept sample at a time and does not take the next before
// it is through: queue pop, ring read, sum update, the divider at four quotient
// bits per cycle, and the compare. A pending output holds only the compare.
module adc_average_delta_report #(
  parameter int CHANNELS    = 4,
  parameter int AVG_SAMPLES = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // chan[1:0], raw_sample[13:2], zero[15:14]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // report_chan[1:0], report_level[13:2], zero[15:14]
  input  logic        wr_en,
  input  logic [2:0]  wr_index,
  input  logic [11:0] wr_data
);
  import adc_avg_pkg::*;

  item_t             in_item;
  item_t             push_item;
  item_t             pop_item;
  cfg_t              cfg;
  logic              push;
  logic              pop;
  logic              fifo_full;
  logic              fifo_empty;
  logic [CHAN_W-1:0] report_chan;
  level_t            report_level;

  assign in_item.chan   = s_axis_tdata[CHAN_W-1:0];
  assign in_item.sample = s_axis_tdata[CHAN_W+SAMPLE_W-1:CHAN_W];
  assign m_axis_tdata   = {2'b00, report_level, report_chan};

  adc_avg_front #(
    .CHANNELS (CHANNELS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .in_item       (in_item),
    .wr_en         (wr_en),
    .wr_index      (wr_index),
    .wr_data       (wr_data),
    .fifo_full     (fifo_full),
    .push          (push),
    .push_item     (push_item),
    .cfg           (cfg)
  );

  adc_avg_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (fifo_full),
    .pop       (pop),
    .pop_item  (pop_item),
    .empty     (fifo_empty)
  );

  adc_avg_back #(
    .CHANNELS    (CHANNELS),
    .AVG_SAMPLES (AVG_SAMPLES)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .fifo_empty    (fifo_empty),
    .pop_item      (pop_item),
    .pop           (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .report_chan   (report_chan),
    .report_level  (report_level)
  );

endmodule

### dv/tb_adc_average_delta_report.sv
// testbench for adc_average_delta_report: per-channel moving average with deadband reports
// drives sample requests and register writes, predicts each report, checks the output stream
// depends on adc_avg_pkg and the adc_average_delta_report top level
`timescale 1ns / 1ps

module tb_adc_average_delta_report;
  import adc_avg_pkg::*;

  localparam int NUM_CH   = 4;
  localparam int RING_LEN = 8;
  localparam int PAD_W    = 16 - CHAN_W - SAMPLE_W;
  localparam int SETTLE_CYCLES = 64;
  localparam int MIN_RANDOM_REPORTS = 48;

  typedef struct packed {
    logic [CHAN_W-1:0] chan;
    level_t            level;
  } report_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;  // chan[1:0], raw_sample[13:2], zero[15:14]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;       // report_chan[1:0], report_level[13:2], zero[15:14]
  logic        wr_en = 1'b0;
  logic [2:0]  wr_index = '0;
  logic [11:0] wr_data = '0;

  // predictor state: enables, deadbands, rings, last reported levels
  logic [NUM_CH-1:0] en_mask;
  level_t            deadband [NUM_CH];
  level_t            ring     [NUM_CH][RING_LEN];
  bit                filled   [NUM_CH][RING_LEN];
  int unsigned       head     [NUM_CH];
  level_t            last_lvl [NUM_CH];

  report_t expected_reports[$];
  int send_idle = 0;
  int recv_idle = 0;
  int hold_cnt = 0;
  int errors = 0;
  int samples_sent = 0;
  int samples_kept = 0;
  int reports_predicted = 0;
  int reports_checked = 0;
  int reg_writes = 0;

  adc_average_delta_report uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .wr_en         (wr_en),
    .wr_index      (wr_index),
    .wr_data       (wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("tb_adc_average_delta_report NOT OK");
    $finish;
  end

  // receiver: random stalls, or a long hold-off counted here
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_cnt > 0) begin
      m_axis_tready <= 1'b0;
      hold_cnt <= hold_cnt - 1;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  // report checker
  always @(posedge clk) begin
    report_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_reports.size() == 0) begin
        $error("unexpected report: chan %0d level %0d", m_axis_tdata[CHAN_W-1:0],
               m_axis_tdata[CHAN_W+SAMPLE_W-1:CHAN_W]);
        errors++;
      end else begin
        want = expected_reports.pop_front();
        reports_checked++;
        if (m_axis_tdata[CHAN_W-1:0] !== want.chan) begin
          $error("report_chan: expected %0d, got %0d", want.chan, m_axis_tdata[CHAN_W-1:0]);
          errors++;
        end
        if (m_axis_tdata[CHAN_W+SAMPLE_W-1:CHAN_W] !== want.level) begin
          $error("report_level: expected %0d, got %0d", want.level,
                 m_axis_tdata[CHAN_W+SAMPLE_W-1:CHAN_W]);
          errors++;
        end
        if (m_axis_tdata[15:CHAN_W+SAMPLE_W] !== '0) begin
          $error("tdata pad: expected 0, got %0h", m_axis_tdata[15:CHAN_W+SAMPLE_W]);
          errors++;
        end
      end
    end
  end

  // average of the filled ring entries against the deadband around the last report
  function automatic bit predict_report(input logic [CHAN_W-1:0] ch, input level_t smp,
                                        output report_t rep);
    int unsigned total = 0;
    int unsigned count = 0;
    int unsigned lvl;
    int unsigned prev;
    int unsigned d;
    bit hit = 1'b0;
    rep = '0;
    if (!en_mask[ch]) return 1'b0;
    ring[ch][head[ch]] = smp;
    filled[ch][head[ch]] = 1'b1;
    head[ch] = (head[ch] + 1) % RING_LEN;
    for (int i = 0; i < RING_LEN; i++) begin
      if (filled[ch][i]) begin
        total += ring[ch][i];
        count++;
      end
    end
    lvl = total / count;
    prev = last_lvl[ch];
    d = deadband[ch];
    if (lvl > prev) hit = (prev + d < lvl);
    else if (lvl < prev) hit = (prev >= d) && (prev - d > lvl);
    if (hit) begin
      last_lvl[ch] = level_t'(lvl);
      rep.chan = ch;
      rep.level = level_t'(lvl);
      reports_predicted++;
    end
    return hit;
  endfunction

  task automatic reset_model();
    en_mask = '0;
    for (int c = 0; c < NUM_CH; c++) begin
      deadband[c] = '0;
      head[c] = 0;
      last_lvl[c] = '0;
      for (int i = 0; i < RING_LEN; i++) begin
        ring[c][i] = '0;
        filled[c][i] = 1'b0;
      end
    end
  endtask

  // one register write; only while the block is idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    @(posedge clk);
    wr_en <= 1'b0;
    reg_writes++;
    if (idx == REG_CHANNEL_ENABLE) begin
      // a channel switched on starts from a zero last level
      for (int c = 0; c < NUM_CH; c++)
        if (val[c] && !en_mask[c]) last_lvl[c] = '0;
      en_mask = val[NUM_CH-1:0];
    end else if (idx >= REG_DELTA_CH0 && idx <= REG_DELTA_CH3) begin
      deadband[idx - REG_DELTA_CH0] = val;
    end
    @(posedge clk);
  endtask

  // one sample request, with random idle gaps before it
  task automatic send_sample(input logic [CHAN_W-1:0] ch, input level_t smp);
    report_t rep;
    while ($urandom_range(0, 99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {{PAD_W{1'b0}}, smp, ch};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    samples_sent++;
    if (en_mask[ch]) samples_kept++;
    if (predict_report(ch, smp, rep)) expected_reports.push_back(rep);
  endtask

  // drain all reports, then let dropped or silent samples finish
  task automatic quiesce();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic level_t pick_deadband();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return level_t'($urandom_range(0, 15));
      5, 6, 7, 8: return level_t'($urandom_range(0, 300));
      default: return level_t'($urandom_range(0, 4095));
    endcase
  endfunction

  task automatic randomize_settings();
    logic [CFG_DATA_W-1:0] val;
    int pick;
    quiesce();
    pick = $urandom_range(0, 11);
    val = CFG_DATA_W'($urandom);
    if (pick == 0) val[NUM_CH-1:0] = '0;
    else if (pick < 5) val[NUM_CH-1:0] = '1;
    write_reg(REG_CHANNEL_ENABLE, val);
    for (int c = 0; c < NUM_DELTAS; c++)
      write_reg(CFG_IDX_W'(REG_DELTA_CH0 + c), pick_deadband());
    // writes to unused indexes must change nothing
    if ($urandom_range(0, 3) == 0)
      write_reg(CFG_IDX_W'($urandom_range(REG_DELTA_CH3 + 1, 2**CFG_IDX_W - 1)),
                CFG_DATA_W'($urandom));
  endtask

  // mix of full-range, rail and near-deadband samples
  task automatic random_batch(input int attempts);
    logic [CHAN_W-1:0] ch;
    int kind;
    int span;
    int v;
    for (int n = 0; n < attempts; n++) begin
      ch = CHAN_W'($urandom_range(0, NUM_CH - 1));
      kind = $urandom_range(0, 99);
      if (kind < 35) begin
        v = $urandom_range(0, 4095);
      end else if (kind < 45) begin
        v = $urandom_range(0, 1) ? 4095 : 0;
      end else begin
        span = int'(deadband[ch]) + 24;
        if (span > 600) span = 600;
        v = int'(last_lvl[ch]) + int'($urandom_range(0, 2 * span)) - span;
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
      end
      send_sample(ch, level_t'(v));
    end
  endtask

  // extremes, enable handling, both deadband directions, ring wrap
  task automatic test_directed();
    // nothing is enabled after reset
    send_sample(2'd3, 12'hFFF);
    quiesce();
    write_reg(REG_CHANNEL_ENABLE, 12'h00F);
    send_sample(2'd0, 12'hFFF);
    send_sample(2'd1, 12'h000);
    send_sample(2'd0, 12'h000);
    send_sample(2'd2, 12'hFFF);
    send_sample(2'd3, 12'hFFF);
    // downward test with last level below the deadband never fires
    send_sample(2'd1, 12'd10);
    quiesce();
    write_reg(CFG_IDX_W'(REG_DELTA_CH0 + 1), 12'd50);
    send_sample(2'd1, 12'h000);
    send_sample(2'd1, 12'h000);
    quiesce();
    // upward change within the deadband
    write_reg(CFG_IDX_W'(REG_DELTA_CH0 + 1), 12'hFFF);
    send_sample(2'd1, 12'hFFF);
    quiesce();
    // re-enabling clears the last level but keeps the ring
    write_reg(REG_DELTA_CH0, 12'd1000);
    write_reg(REG_CHANNEL_ENABLE, 12'hFF0);
    write_reg(REG_CHANNEL_ENABLE, 12'h00F);
    for (int i = REG_DELTA_CH3 + 1; i < 2**CFG_IDX_W; i++)
      write_reg(CFG_IDX_W'(i), 12'hFFF);
    write_reg(CFG_IDX_W'(REG_DELTA_CH0 + 2), 12'h000);
    write_reg(REG_DELTA_CH3, 12'h800);
    send_sample(2'd0, 12'hFFF);
    // more than a ring's worth on one channel
    for (int i = 0; i < RING_LEN + 2; i++)
      send_sample(2'd2, (i % 3 == 0) ? 12'h000 : 12'hA5A ^ 12'(i * 37));
    quiesce();
  endtask

  task automatic test_random_traffic(input int target);
    int start = samples_sent;
    while (samples_sent - start < target) begin
      randomize_settings();
      random_batch(30);
    end
  endtask

  // receiver holds off while the sender keeps offering reporting samples
  task automatic test_output_backpressure();
    quiesce();
    write_reg(REG_CHANNEL_ENABLE, 12'h00F);
    for (int c = 0; c < NUM_DELTAS; c++)
      write_reg(CFG_IDX_W'(REG_DELTA_CH0 + c), '0);
    hold_cnt <= 400;
    for (int i = 0; i < 24; i++)
      send_sample(CHAN_W'(i % 2), (i % 4 < 2) ? 12'hFFF : 12'h000);
    quiesce();
  endtask

  task automatic test_until_reports(input int base);
    int guard = 0;
    while (reports_predicted - base < MIN_RANDOM_REPORTS && guard < 20) begin
      randomize_settings();
      random_batch(30);
      guard++;
    end
  endtask

  initial begin
    int random_base;
    reset_model();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    send_idle = 37;
    recv_idle = 48;
    test_directed();
    random_base = reports_predicted;
    test_random_traffic(195);
    send_idle = 48;
    recv_idle = 37;
    test_random_traffic(195);
    send_idle = 0;
    recv_idle = 0;
    test_output_backpressure();
    test_random_traffic(195);
    test_until_reports(random_base);
    quiesce();
    if (expected_reports.size() != 0) begin
      $error("%0d expected reports never arrived", expected_reports.size());
      errors++;
    end
    $display("run covered %0d samples sent, %0d kept, %0d reports checked, %0d register writes",
             samples_sent, samples_kept, reports_checked, reg_writes);
    if (errors == 0) begin
      $display("tb_adc_average_delta_report OK");
    end else begin
      $display("tb_adc_average_delta_report NOT OK");
    end
    $finish;
  end

endmodule

### filelist.f
design/adc_avg_pkg.sv
design/adc_avg_front.sv
design/adc_avg_fifo.sv
design/adc_avg_back.sv
design/adc_average_delta_report.sv
dv/tb_adc_average_delta_report.sv
